// File: rtl/core/mtp_pkg.sv
package mtp_pkg;

  // token kinds
  localparam logic [3:0] KIND_MAP     = 4'd0;
  localparam logic [3:0] KIND_ARRAY   = 4'd1;
  localparam logic [3:0] KIND_STRHDR  = 4'd2;
  localparam logic [3:0] KIND_STRBYTE = 4'd3;
  localparam logic [3:0] KIND_BOOL    = 4'd4;
  localparam logic [3:0] KIND_UINT    = 4'd5;
  localparam logic [3:0] KIND_F32     = 4'd6;
  localparam logic [3:0] KIND_F64     = 4'd7;
  localparam logic [3:0] KIND_UNSUP   = 4'd8;
  localparam logic [3:0] KIND_TRUNC   = 4'd9;

  // format codes beyond the fixed ranges; all but false and true open a multi-byte item
  localparam logic [7:0] CODE_FALSE   = 8'hc2;
  localparam logic [7:0] CODE_TRUE    = 8'hc3;
  localparam logic [7:0] CODE_FLOAT32 = 8'hca;
  localparam logic [7:0] CODE_FLOAT64 = 8'hcb;
  localparam logic [7:0] CODE_STR8    = 8'hd9;
  localparam logic [7:0] CODE_STR16   = 8'hda;
  localparam logic [7:0] CODE_STR32   = 8'hdb;
  localparam logic [7:0] CODE_MAP16   = 8'hde;
  localparam logic [7:0] CODE_MAP32   = 8'hdf;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // what a byte means when it starts a new item
  typedef struct packed {
    logic       emit;
    logic [3:0] kind;
    logic [7:0] value;
    logic [3:0] count;
  } mtp_class_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    mtp_class_t cls;
  } mtp_item_t;

endpackage

// File: rtl/core/mtp_front.sv
module mtp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  input  logic                end_of_message_i,
  input  logic                full_i,
  output logic                push_o,
  output mtp_pkg::mtp_item_t  item_o
);

  mtp_pkg::mtp_class_t cls;
  logic                seen_q;
  logic                seen_d;

  always_comb begin
    cls.emit  = 1'b1;
    cls.kind  = mtp_pkg::KIND_UNSUP;
    cls.value = in_byte_i;
    cls.count = 4'd0;
    unique case (in_byte_i) inside
      [8'h00:8'h7f]: begin
        cls.kind = mtp_pkg::KIND_UINT;
      end
      [8'h80:8'h8f]: begin
        cls.kind  = mtp_pkg::KIND_MAP;
        cls.value = {4'd0, in_byte_i[3:0]};
      end
      [8'h90:8'h9f]: begin
        cls.kind  = mtp_pkg::KIND_ARRAY;
        cls.value = {4'd0, in_byte_i[3:0]};
      end
      [8'ha0:8'hbf]: begin
        cls.kind  = mtp_pkg::KIND_STRHDR;
        cls.value = {3'd0, in_byte_i[4:0]};
      end
      mtp_pkg::CODE_FALSE, mtp_pkg::CODE_TRUE: begin
        cls.kind  = mtp_pkg::KIND_BOOL;
        cls.value = {7'd0, in_byte_i[0]};
      end
      mtp_pkg::CODE_FLOAT32: begin
        cls.emit  = 1'b0;
        cls.kind  = mtp_pkg::KIND_F32;
        cls.count = 4'd4;
      end
      mtp_pkg::CODE_FLOAT64: begin
        cls.emit  = 1'b0;
        cls.kind  = mtp_pkg::KIND_F64;
        cls.count = 4'd8;
      end
      mtp_pkg::CODE_STR8: begin
        cls.emit  = 1'b0;
        cls.kind  = mtp_pkg::KIND_STRHDR;
        cls.count = 4'd1;
      end
      mtp_pkg::CODE_STR16: begin
        cls.emit  = 1'b0;
        cls.kind  = mtp_pkg::KIND_STRHDR;
        cls.count = 4'd2;
      end
      mtp_pkg::CODE_STR32: begin
        cls.emit  = 1'b0;
        cls.kind  = mtp_pkg::KIND_STRHDR;
        cls.count = 4'd4;
      end
      mtp_pkg::CODE_MAP16: begin
        cls.emit  = 1'b0;
        cls.kind  = mtp_pkg::KIND_MAP;
        cls.count = 4'd2;
      end
      mtp_pkg::CODE_MAP32: begin
        cls.emit  = 1'b0;
        cls.kind  = mtp_pkg::KIND_MAP;
        cls.count = 4'd4;
      end
      default: begin
        cls.kind = mtp_pkg::KIND_UNSUP;
      end
    endcase
  end

  assign in_stall_o    = full_i;
  assign push_o        = in_valid_i && !full_i;
  assign item_o.data   = in_byte_i;
  assign item_o.eom    = end_of_message_i;
  assign item_o.cls    = cls;

  // tracks whether a message is open, for the checks below
  assign seen_d = push_o ? !end_of_message_i : seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o) else $error("push into full queue");
  a_collect_code_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls.count != 4'd0) |-> !cls.emit) else $error("collect code emits");
  a_open_tracks_eom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && end_of_message_i) |=> !seen_q) else $error("message still open");
`endif

endmodule

// File: rtl/core/mtp_fifo.sv
module mtp_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mtp_pkg::mtp_item_t item_i,
  input  logic               pop_i,
  output mtp_pkg::mtp_item_t item_o,
  output logic               full_o,
  output logic               empty_o
);

  mtp_pkg::mtp_item_t                 mem_q [mtp_pkg::FIFO_DEPTH];
  logic [mtp_pkg::FIFO_AW-1:0]        wptr_q;
  logic [mtp_pkg::FIFO_AW-1:0]        wptr_d;
  logic [mtp_pkg::FIFO_AW-1:0]        rptr_q;
  logic [mtp_pkg::FIFO_AW-1:0]        rptr_d;
  logic [mtp_pkg::FIFO_CW-1:0]        count_q;
  logic [mtp_pkg::FIFO_CW-1:0]        count_d;

  localparam logic [mtp_pkg::FIFO_AW-1:0] LastIdx = mtp_pkg::FIFO_AW'(mtp_pkg::FIFO_DEPTH - 1);
  localparam logic [mtp_pkg::FIFO_CW-1:0] FullCnt = mtp_pkg::FIFO_CW'(mtp_pkg::FIFO_DEPTH);

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCnt) |-> (wptr_q == rptr_q))
    else $error("pointers disagree with count");
`endif

endmodule

// File: rtl/core/mtp_back.sv
module mtp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  mtp_pkg::mtp_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         token_kind_o,
  output logic [63:0]        token_value_o,
  output logic               end_mark_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_STRING  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  hdr_left_q, hdr_left_d;
  logic [3:0]  pend_kind_q, pend_kind_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] str_left_q, str_left_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  kind_q, kind_d;
  logic [63:0] value_q, value_d;
  logic        end_q, end_d;

  logic        emit;
  logic [3:0]  kind;
  logic [63:0] value;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !empty_i && out_free;

  always_comb begin
    phase_d     = phase_q;
    hdr_left_d  = hdr_left_q;
    pend_kind_d = pend_kind_q;
    acc_d       = acc_q;
    str_left_d  = str_left_q;
    emit        = 1'b0;
    kind        = mtp_pkg::KIND_MAP;
    value       = '0;
    if (pop_o) begin
      unique case (phase_q)
        PH_COLLECT: begin
          acc_d      = {acc_q[55:0], item_i.data};
          hdr_left_d = hdr_left_q - {3'd0, hdr_left_q != 4'd0};
          if (hdr_left_d == 4'd0) begin
            emit    = 1'b1;
            kind    = pend_kind_q;
            value   = acc_d;
            phase_d = PH_IDLE;
            if (pend_kind_q == mtp_pkg::KIND_STRHDR && acc_d[31:0] != 32'd0) begin
              phase_d    = PH_STRING;
              str_left_d = acc_d[31:0];
            end
          end
        end
        PH_STRING: begin
          emit       = 1'b1;
          kind       = mtp_pkg::KIND_STRBYTE;
          value      = {56'd0, item_i.data};
          str_left_d = str_left_q - 32'd1;
          if (str_left_d == 32'd0) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          emit    = item_i.cls.emit;
          kind    = item_i.cls.kind;
          value   = {56'd0, item_i.cls.value};
          if (!item_i.cls.emit) begin
            phase_d     = PH_COLLECT;
            pend_kind_d = item_i.cls.kind;
            hdr_left_d  = item_i.cls.count;
            acc_d       = '0;
          end else if (item_i.cls.kind == mtp_pkg::KIND_STRHDR &&
                       item_i.cls.value != 8'd0) begin
            phase_d    = PH_STRING;
            str_left_d = {24'd0, item_i.cls.value};
          end
        end
      endcase
      if (item_i.eom) begin
        // message ends: report what is still missing, then start fresh
        if (phase_d == PH_COLLECT) begin
          emit  = 1'b1;
          kind  = mtp_pkg::KIND_TRUNC;
          value = {60'd0, hdr_left_d};
        end else if (phase_d == PH_STRING) begin
          emit  = 1'b1;
          kind  = mtp_pkg::KIND_TRUNC;
          value = {32'd0, str_left_d};
        end
        phase_d     = PH_IDLE;
        hdr_left_d  = '0;
        pend_kind_d = '0;
        acc_d       = '0;
        str_left_d  = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    value_d     = value_q;
    end_d       = end_q;
    if (out_free) begin
      out_valid_d = pop_o && emit;
      if (pop_o && emit) begin
        kind_d  = kind;
        value_d = value;
        end_d   = item_i.eom;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hdr_left_q  <= '0;
      pend_kind_q <= '0;
      acc_q       <= '0;
      str_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_left_q  <= hdr_left_d;
      pend_kind_q <= pend_kind_d;
      acc_q       <= acc_d;
      str_left_q  <= str_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    end_q   <= end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign token_value_o = value_q;
  assign end_mark_o    = end_q;

`ifndef SYNTHESIS
  a_string_has_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STRING) |-> (str_left_q != 32'd0)) else $error("empty string phase");
  a_collect_has_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COLLECT) |-> (hdr_left_q != 4'd0)) else $error("empty collect phase");
  a_eom_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.eom) |=> (phase_q == PH_IDLE && end_mark_o && out_valid_o))
    else $error("message end did not reset or report");
  a_no_pop_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o) else $error("pop while output blocked");
`endif

endmodule

// File: rtl/core/msgpack_token_parser.sv
// Byte-serial MessagePack tokenizer: one message byte in per transaction, at most one token
// out. Sustained rate is one byte per clock unless the queue fills or the output stalls;
// a byte is decoded by the input classifier, waits in a 4-entry queue and is then run through
// the token state machine, whose output register holds the token. Bytes inside a multi-byte
// header or float give no token until the last one; a message cut short gives a truncated token
// carrying the bytes still missing, and every end-of-message byte gives one.
module msgpack_token_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [63:0] token_value_o,
  output logic        end_mark_o
);

  mtp_pkg::mtp_item_t push_item;
  mtp_pkg::mtp_item_t pop_item;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;

  mtp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .end_of_message_i (end_of_message_i),
    .full_i           (full),
    .push_o           (push),
    .item_o           (push_item)
  );

  mtp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (full),
    .empty_o (empty)
  );

  mtp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .end_mark_o    (end_mark_o)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {PH_IDLE, PH_COLLECT, PH_STRING} parse_phase_e;

  typedef enum int {
    GEN_FIXINT, GEN_FIXMAP, GEN_FIXARR, GEN_BOOL, GEN_FIXSTR, GEN_STR8, GEN_STR16,
    GEN_STR32, GEN_F32, GEN_F64, GEN_MAP16, GEN_MAP32, GEN_UNSUP, GEN_NOISE
  } gen_kind_e;

  localparam logic [7:0] FIXINT_MAX  = 8'h7f;
  localparam logic [7:0] FIXMAP_BASE = 8'h80;
  localparam logic [7:0] FIXMAP_MAX  = 8'h8f;
  localparam logic [7:0] FIXARR_BASE = 8'h90;
  localparam logic [7:0] FIXARR_MAX  = 8'h9f;
  localparam logic [7:0] FIXSTR_BASE = 8'ha0;
  localparam logic [7:0] FIXSTR_MAX  = 8'hbf;
  localparam logic [7:0] UNSUP_BASE  = 8'hc0;

  localparam int unsigned QUIET_LIMIT     = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned BODY_MAX        = 40;
  localparam int unsigned SRC_IDLE  [4]   = '{0, 79, 0, 9};
  localparam int unsigned DST_STALL [4]   = '{0, 0, 79, 9};

  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic        fixed;
    logic [3:0]  kind;
    logic [63:0] value;
  } stim_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last;
  } token_t;

  // rows with fixed set carry their own expected token, the rest go through the predictor
  localparam stim_t DIRECTED [26] = '{
    '{8'h00, 1'b0, 1'b1, mtp_pkg::KIND_UINT,   64'd0},
    '{8'h7f, 1'b0, 1'b1, mtp_pkg::KIND_UINT,   64'd127},
    '{8'h80, 1'b0, 1'b1, mtp_pkg::KIND_MAP,    64'd0},
    '{8'h8f, 1'b0, 1'b1, mtp_pkg::KIND_MAP,    64'd15},
    '{8'h90, 1'b0, 1'b1, mtp_pkg::KIND_ARRAY,  64'd0},
    '{8'h9f, 1'b0, 1'b1, mtp_pkg::KIND_ARRAY,  64'd15},
    '{8'hc3, 1'b0, 1'b1, mtp_pkg::KIND_BOOL,   64'd1},
    '{8'hc2, 1'b0, 1'b1, mtp_pkg::KIND_BOOL,   64'd0},
    '{8'hc1, 1'b0, 1'b1, mtp_pkg::KIND_UNSUP,  64'hc1},
    '{8'hff, 1'b0, 1'b1, mtp_pkg::KIND_UNSUP,  64'hff},
    '{8'ha0, 1'b0, 1'b1, mtp_pkg::KIND_STRHDR, 64'd0},
    '{8'ha1, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'h80, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'hd9, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'h01, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'hff, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'hde, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'hff, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'hff, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'hca, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'h3f, 1'b0, 1'b0, 4'd0,                 64'd0},
    '{8'h80, 1'b1, 1'b1, mtp_pkg::KIND_TRUNC,  64'd2},
    '{8'hbf, 1'b0, 1'b1, mtp_pkg::KIND_STRHDR, 64'd31},
    '{8'h41, 1'b1, 1'b1, mtp_pkg::KIND_TRUNC,  64'd30},
    '{8'hcb, 1'b1, 1'b1, mtp_pkg::KIND_TRUNC,  64'd8},
    '{8'hc3, 1'b1, 1'b1, mtp_pkg::KIND_BOOL,   64'd1}
  };

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i        = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [3:0]  token_kind_o;
  logic [63:0] token_value_o;
  logic        end_mark_o;

  msgpack_token_parser uut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state, reset values
  parse_phase_e pr_phase  = PH_IDLE;
  logic [3:0]   bytes_due = '0;
  logic [3:0]   due_kind  = '0;
  logic [63:0]  gather    = '0;
  logic [31:0]  str_due   = '0;

  stim_t       bytes_to_send [$];
  token_t      tokens_due [$];
  stim_t       in_flight;
  logic [7:0]  msg_bytes [$];
  logic        msg_cut;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_errors     = 0;

  function automatic void begin_collect(input logic [3:0] kind, input logic [3:0] n);
    pr_phase  = PH_COLLECT;
    due_kind  = kind;
    bytes_due = n;
    gather    = '0;
  endfunction

  function automatic void open_string(input logic [31:0] len);
    if (len != 0) begin
      pr_phase = PH_STRING;
      str_due  = len;
    end else begin
      pr_phase = PH_IDLE;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eom,
                                      output logic emit, output token_t tok);
    emit = 1'b0;
    tok  = '{kind: mtp_pkg::KIND_MAP, value: '0, last: eom};
    case (pr_phase)
      PH_COLLECT: begin
        gather = {gather[55:0], b};
        if (bytes_due != 0) bytes_due--;
        if (bytes_due == 0) begin
          emit      = 1'b1;
          tok.kind  = due_kind;
          tok.value = gather;
          pr_phase  = PH_IDLE;
          if (due_kind == mtp_pkg::KIND_STRHDR) open_string(gather[31:0]);
        end
      end
      PH_STRING: begin
        emit      = 1'b1;
        tok.kind  = mtp_pkg::KIND_STRBYTE;
        tok.value = 64'(b);
        str_due--;
        if (str_due == 0) pr_phase = PH_IDLE;
      end
      default: begin
        pr_phase = PH_IDLE;
        emit     = 1'b1;
        if (b <= FIXINT_MAX) begin
          tok.kind  = mtp_pkg::KIND_UINT;
          tok.value = 64'(b);
        end else if (b <= FIXMAP_MAX) begin
          tok.kind  = mtp_pkg::KIND_MAP;
          tok.value = 64'(b - FIXMAP_BASE);
        end else if (b <= FIXARR_MAX) begin
          tok.kind  = mtp_pkg::KIND_ARRAY;
          tok.value = 64'(b - FIXARR_BASE);
        end else if (b <= FIXSTR_MAX) begin
          tok.kind  = mtp_pkg::KIND_STRHDR;
          tok.value = 64'(b - FIXSTR_BASE);
          open_string(32'(b - FIXSTR_BASE));
        end else begin
          case (b)
            mtp_pkg::CODE_FALSE, mtp_pkg::CODE_TRUE: begin
              tok.kind  = mtp_pkg::KIND_BOOL;
              tok.value = 64'(b == mtp_pkg::CODE_TRUE);
            end
            mtp_pkg::CODE_FLOAT32: begin
              emit = 1'b0; begin_collect(mtp_pkg::KIND_F32, 4'd4);
            end
            mtp_pkg::CODE_FLOAT64: begin
              emit = 1'b0; begin_collect(mtp_pkg::KIND_F64, 4'd8);
            end
            mtp_pkg::CODE_STR8: begin
              emit = 1'b0; begin_collect(mtp_pkg::KIND_STRHDR, 4'd1);
            end
            mtp_pkg::CODE_STR16: begin
              emit = 1'b0; begin_collect(mtp_pkg::KIND_STRHDR, 4'd2);
            end
            mtp_pkg::CODE_STR32: begin
              emit = 1'b0; begin_collect(mtp_pkg::KIND_STRHDR, 4'd4);
            end
            mtp_pkg::CODE_MAP16: begin
              emit = 1'b0; begin_collect(mtp_pkg::KIND_MAP, 4'd2);
            end
            mtp_pkg::CODE_MAP32: begin
              emit = 1'b0; begin_collect(mtp_pkg::KIND_MAP, 4'd4);
            end
            default: begin
              tok.kind  = mtp_pkg::KIND_UNSUP;
              tok.value = 64'(b);
            end
          endcase
        end
      end
    endcase
    // message end: report what is still missing, then back to reset state
    if (eom) begin
      if (pr_phase == PH_COLLECT) begin
        emit      = 1'b1;
        tok.kind  = mtp_pkg::KIND_TRUNC;
        tok.value = 64'(bytes_due);
      end else if (pr_phase == PH_STRING) begin
        emit      = 1'b1;
        tok.kind  = mtp_pkg::KIND_TRUNC;
        tok.value = 64'(str_due);
      end
      pr_phase  = PH_IDLE;
      bytes_due = '0;
      due_kind  = '0;
      gather    = '0;
      str_due   = '0;
    end
  endfunction

  task automatic push_be(input logic [63:0] v, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
  endtask

  // mostly short lengths, now and then one at full width
  function automatic logic [31:0] pick_len(input int unsigned bits);
    logic [63:0] full;
    full = {$urandom, $urandom};
    if ($urandom_range(5) == 0) return 32'(full & ((64'd1 << bits) - 1));
    return $urandom_range(12);
  endfunction

  task automatic add_body(input logic [31:0] len);
    int unsigned n;
    n = (len > BODY_MAX) ? $urandom_range(20) : len;
    repeat (n) msg_bytes.push_back(8'($urandom));
    // too long to send whole, so the message ends inside the body
    if (len > BODY_MAX) msg_cut = 1'b1;
  endtask

  task automatic add_item();
    gen_kind_e   sel;
    logic [7:0]  code;
    logic [31:0] len;
    sel = gen_kind_e'($urandom_range(GEN_NOISE));
    case (sel)
      GEN_FIXINT: msg_bytes.push_back(8'($urandom_range(FIXINT_MAX)));
      GEN_FIXMAP: msg_bytes.push_back(FIXMAP_BASE | 8'($urandom_range(15)));
      GEN_FIXARR: msg_bytes.push_back(FIXARR_BASE | 8'($urandom_range(15)));
      GEN_BOOL:   msg_bytes.push_back($urandom_range(1) ? mtp_pkg::CODE_TRUE
                                                        : mtp_pkg::CODE_FALSE);
      GEN_FIXSTR: begin
        len = $urandom_range(31);
        msg_bytes.push_back(FIXSTR_BASE | 8'(len));
        add_body(len);
      end
      GEN_STR8: begin
        len = pick_len(8);
        msg_bytes.push_back(mtp_pkg::CODE_STR8);
        push_be(64'(len), 1);
        add_body(len);
      end
      GEN_STR16: begin
        len = pick_len(16);
        msg_bytes.push_back(mtp_pkg::CODE_STR16);
        push_be(64'(len), 2);
        add_body(len);
      end
      GEN_STR32: begin
        len = pick_len(32);
        msg_bytes.push_back(mtp_pkg::CODE_STR32);
        push_be(64'(len), 4);
        add_body(len);
      end
      GEN_F32: begin
        msg_bytes.push_back(mtp_pkg::CODE_FLOAT32);
        push_be(64'($urandom), 4);
      end
      GEN_F64: begin
        msg_bytes.push_back(mtp_pkg::CODE_FLOAT64);
        push_be({$urandom, $urandom}, 8);
      end
      GEN_MAP16: begin
        msg_bytes.push_back(mtp_pkg::CODE_MAP16);
        push_be(64'($urandom), 2);
      end
      GEN_MAP32: begin
        msg_bytes.push_back(mtp_pkg::CODE_MAP32);
        push_be(64'($urandom), 4);
      end
      GEN_UNSUP: begin
        do code = 8'($urandom_range(8'hff, UNSUP_BASE));
        while (code inside {mtp_pkg::CODE_FALSE, mtp_pkg::CODE_TRUE,
                            mtp_pkg::CODE_FLOAT32, mtp_pkg::CODE_FLOAT64,
                            mtp_pkg::CODE_STR8, mtp_pkg::CODE_STR16, mtp_pkg::CODE_STR32,
                            mtp_pkg::CODE_MAP16, mtp_pkg::CODE_MAP32});
        msg_bytes.push_back(code);
      end
      default: msg_bytes.push_back(8'($urandom));
    endcase
  endtask

  task automatic add_message();
    int unsigned n_items;
    int unsigned cut;
    msg_bytes.delete();
    msg_cut = 1'b0;
    n_items = $urandom_range(6, 1);
    for (int i = 0; i < n_items && !msg_cut; i++) add_item();
    cut = msg_bytes.size();
    // some messages are broken off at a random byte
    if (!msg_cut && $urandom_range(7) == 0) cut = $urandom_range(cut, 1);
    for (int i = 0; i < cut; i++)
      bytes_to_send.push_back('{data: msg_bytes[i], eom: (i == cut - 1), fixed: 1'b0,
                                kind: '0, value: '0});
  endtask

  always @(posedge clk_i) begin : send_bytes
    logic   emit;
    token_t tok;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_flight.data, in_flight.eom, emit, tok);
        if (in_flight.fixed)
          tokens_due.push_back('{kind: in_flight.kind, value: in_flight.value,
                                 last: in_flight.eom});
        else if (emit)
          tokens_due.push_back(tok);
      end
      // a stalled transaction holds its payload
      if (!in_valid_i || !in_stall_o) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_flight = bytes_to_send.pop_front();
          in_valid_i       <= 1'b1;
          in_byte_i        <= in_flight.data;
          end_of_message_i <= in_flight.eom;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_tokens
    token_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (tokens_due.size() == 0) begin
          $error("unexpected token: kind %0d value 0x%0h", token_kind_o, token_value_o);
          n_errors++;
        end else begin
          want = tokens_due.pop_front();
          if (token_kind_o !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, token_kind_o);
            n_errors++;
          end
          if (token_value_o !== want.value) begin
            $error("token_value: expected 0x%0h, got 0x%0h", want.value, token_value_o);
            n_errors++;
          end
          if (end_mark_o !== want.last) begin
            $error("end_mark: expected %0b, got %0b", want.last, end_mark_o);
            n_errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DIRECTED[i]) bytes_to_send.push_back(DIRECTED[i]);
    for (int p = 0; p < 4; p++) begin
      idle_pct  = SRC_IDLE[p];
      stall_pct = DST_STALL[p];
      while (bytes_to_send.size() < ITEMS_PER_PHASE) add_message();
      while (bytes_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    end
    while (tokens_due.size() != 0) @(posedge clk_i);
    // catch any token the block sends beyond the last expected one
    repeat (16) @(posedge clk_i);
    if (n_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
